// File: hw/rtl/wlp_pkg.sv
// Package of constants, register codes and shared types for the weighing line parser.
package wlp_pkg;

    localparam int MAX_LINE   = 23;
    localparam int MAX_DIGITS = 10;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 5;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] TOKEN_MAX  = 3'd5;
    localparam logic [2:0] TOKEN_WGT  = 3'd3;
    localparam logic [1:0] FIRST_MAX  = 2'd2;

    localparam logic [3:0]       DISCARD_RESET = 4'd1;
    localparam logic [COUNT_W-1:0] MIN_RESET   = 5'd21;

    typedef enum logic [1:0] {
        REG_DISCARD_COUNT   = 2'd0,
        REG_MIN_LINE_LENGTH = 2'd1,
        REG_EXACT_LENGTH    = 2'd2,
        REG_SINGLE_CHANNEL  = 2'd3
    } cfg_index_t;

    // Summary of the line after the current byte, handed from the tokenizer to the top level.
    typedef struct packed {
        logic                closes;
        logic                has_token;
        logic                second_is_t;
        logic                line_has_value;
        logic [WEIGHT_W-1:0] value_accum;
    } line_info_t;

endpackage

// File: hw/rtl/wlp_interfaces.sv
// Handshake interfaces for the byte input, result output and configuration channels.
interface wlp_rx_if;
    import wlp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              channel_select;
    modport source (output valid, output rx_byte, output channel_select, input ready);
    modport sink   (input valid, input rx_byte, input channel_select, output ready);
endinterface

interface wlp_res_if;
    import wlp_pkg::*;
    logic                valid;
    logic                ready;
    logic                to_channel_one;
    logic [WEIGHT_W-1:0] weight;
    logic                is_stable;
    logic [WEIGHT_W-1:0] stable_weight;
    modport source (output valid, output to_channel_one, output weight, output is_stable,
                    output stable_weight, input ready);
    modport sink   (input valid, input to_channel_one, input weight, input is_stable,
                    input stable_weight, output ready);
endinterface

interface wlp_cfg_if;
    import wlp_pkg::*;
    logic             valid;
    logic             ready;
    cfg_index_t       index;
    logic [CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/wlp_tokenizer.sv
// Line collector and comma tokenizer holding the per-line parse state.
module wlp_tokenizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [wlp_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [wlp_pkg::COUNT_W-1:0]    min_line_length,
    input  logic                           exact_length,
    output wlp_pkg::line_info_t            info
);
    import wlp_pkg::*;

    logic [COUNT_W-1:0]  byte_count_reg;
    logic [2:0]          token_index_reg,     token_index_next;
    logic                in_token_reg,        in_token_next;
    logic [1:0]          first_token_pos_reg, first_token_pos_next;
    logic                second_is_t_reg,     second_is_t_next;
    logic                string_ended_reg,    string_ended_next;
    logic                line_has_value_reg,  line_has_value_next;
    logic [3:0]          digit_count_reg,     digit_count_next;
    logic [WEIGHT_W-1:0] value_accum_reg,     value_accum_next;
    logic                closes;
    logic                is_digit;
    logic                line_full;

    assign closes = (rx_byte == CHAR_LF) &&
                    (exact_length ? (byte_count_reg == min_line_length)
                                  : (byte_count_reg >= min_line_length));
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign line_full = (byte_count_reg >= COUNT_W'(MAX_LINE));

    always_comb
    begin
        token_index_next     = token_index_reg;
        in_token_next        = in_token_reg;
        first_token_pos_next = first_token_pos_reg;
        second_is_t_next     = second_is_t_reg;
        string_ended_next    = string_ended_reg;
        line_has_value_next  = line_has_value_reg;
        digit_count_next     = digit_count_reg;
        value_accum_next     = value_accum_reg;
        if (!string_ended_reg)
        begin
            if (rx_byte == CHAR_NUL)
            begin
                string_ended_next = 1'b1;
            end
            else if (rx_byte == CHAR_COMMA)
            begin
                if (in_token_reg)
                begin
                    in_token_next = 1'b0;
                    if (token_index_reg < TOKEN_MAX)
                        token_index_next = token_index_reg + 3'd1;
                end
            end
            else
            begin
                if (!in_token_reg)
                begin
                    in_token_next = 1'b1;
                    if (token_index_reg == 3'd0)
                    begin
                        first_token_pos_next = 2'd0;
                        second_is_t_next     = 1'b0;
                    end
                    else if (token_index_reg == TOKEN_WGT)
                    begin
                        line_has_value_next = 1'b1;
                        value_accum_next    = '0;
                        digit_count_next    = '0;
                    end
                end
                if (token_index_reg == 3'd0)
                begin
                    if (first_token_pos_next == 2'd1 && rx_byte == CHAR_T)
                        second_is_t_next = 1'b1;
                    if (first_token_pos_next < FIRST_MAX)
                        first_token_pos_next = first_token_pos_next + 2'd1;
                end
                else if (token_index_reg == TOKEN_WGT)
                begin
                    if (is_digit && digit_count_next < 4'(MAX_DIGITS))
                    begin
                        value_accum_next = {value_accum_next[WEIGHT_W-4:0], 3'b000}
                                         + {value_accum_next[WEIGHT_W-2:0], 1'b0}
                                         + WEIGHT_W'(rx_byte - CHAR_ZERO);
                        digit_count_next = digit_count_next + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            token_index_reg     <= '0;
            in_token_reg        <= 1'b0;
            first_token_pos_reg <= '0;
            second_is_t_reg     <= 1'b0;
            string_ended_reg    <= 1'b0;
            line_has_value_reg  <= 1'b0;
            digit_count_reg     <= '0;
            value_accum_reg     <= '0;
        end
        else if (fire)
        begin
            if (closes || line_full)
            begin
                byte_count_reg      <= '0;
                token_index_reg     <= '0;
                in_token_reg        <= 1'b0;
                first_token_pos_reg <= '0;
                second_is_t_reg     <= 1'b0;
                string_ended_reg    <= 1'b0;
                line_has_value_reg  <= 1'b0;
                digit_count_reg     <= '0;
                value_accum_reg     <= '0;
            end
            else
            begin
                byte_count_reg      <= byte_count_reg + COUNT_W'(1);
                token_index_reg     <= token_index_next;
                in_token_reg        <= in_token_next;
                first_token_pos_reg <= first_token_pos_next;
                second_is_t_reg     <= second_is_t_next;
                string_ended_reg    <= string_ended_next;
                line_has_value_reg  <= line_has_value_next;
                digit_count_reg     <= digit_count_next;
                value_accum_reg     <= value_accum_next;
            end
        end
    end

    assign info.closes         = closes;
    assign info.has_token      = (token_index_next != 3'd0) || in_token_next;
    assign info.second_is_t    = second_is_t_next;
    assign info.line_has_value = line_has_value_next;
    assign info.value_accum    = value_accum_next;

endmodule

// File: hw/rtl/weighing_line_parser.sv
// Top level of the weighing line parser: channel routing, discards, weights and result register.
//
//  Channel | Role   | Payload                                       | Transaction
//  --------+--------+-----------------------------------------------+---------------------------
//  rx      | sink   | rx_byte, channel_select                       | one received byte
//  res     | source | to_channel_one, weight, is_stable, stable_wgt | one parsed line
//  cfg     | sink   | index, data                                   | one register write
//
// A byte may be taken on every clock edge while rx is not stalled.
// The only storage in the path is the line state and one result register, which
// lets the next byte in while a result waits, so rx stalls only when a result is
// held and res.ready is low. The configuration port is always ready.
// Reset clears all parse state and loads the register defaults (discard count one,
// minimum line length twenty-one).
module weighing_line_parser (
    input  logic      clk,
    input  logic      rst_n,
    wlp_rx_if.sink    rx,
    wlp_res_if.source res,
    wlp_cfg_if.sink   cfg
);
    import wlp_pkg::*;

    // Configuration registers.
    logic [3:0]          discard_count_reg;
    logic [COUNT_W-1:0]  min_line_length_reg;
    logic                exact_length_reg;
    logic                single_channel_reg;

    // Cross-line state.
    logic                old_select_reg;
    logic [3:0]          discard_left_reg;
    logic [WEIGHT_W-1:0] last_value_reg;
    logic                stable_mark_reg;
    logic [WEIGHT_W-1:0] stable_weights_reg [2];

    // Result register.
    logic                out_valid_reg;
    logic                out_ch_one_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;
    logic                out_stable_reg;
    logic [WEIGHT_W-1:0] out_stable_weight_reg;

    line_info_t          info;
    logic                rx_fire;
    logic                res_fire;
    logic                emit;
    logic                ch_one;
    logic                sw_idx;
    logic                mark_next;
    logic [WEIGHT_W-1:0] value_next;
    logic [WEIGHT_W-1:0] stable_weight_next;

    // The result register frees up in the same cycle that the sink takes it.
    assign rx.ready  = !out_valid_reg || res.ready;
    assign rx_fire   = rx.valid && rx.ready;
    assign res_fire  = res.valid && res.ready;
    assign cfg.ready = 1'b1;

    wlp_tokenizer u_tokenizer (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (rx_fire),
        .rx_byte         (rx.rx_byte),
        .min_line_length (min_line_length_reg),
        .exact_length    (exact_length_reg),
        .info            (info)
    );

    // A closed line yields a result unless a channel change or a pending discard
    // swallows it; single channel mode bypasses both and routes to channel one.
    always_comb
    begin
        emit   = 1'b0;
        ch_one = 1'b1;
        if (rx_fire && info.closes)
        begin
            if (single_channel_reg)
            begin
                emit = 1'b1;
            end
            else if (old_select_reg == rx.channel_select && discard_left_reg == 4'd0)
            begin
                emit   = 1'b1;
                ch_one = rx.channel_select;
            end
        end
    end

    // A line with no token keeps the previous stable flag; a line without a
    // fourth token repeats the previous weight.
    assign sw_idx             = !ch_one;
    assign mark_next          = info.has_token ? info.second_is_t : stable_mark_reg;
    assign value_next         = info.line_has_value ? info.value_accum : last_value_reg;
    assign stable_weight_next = mark_next ? value_next : stable_weights_reg[sw_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_count_reg   <= DISCARD_RESET;
            min_line_length_reg <= MIN_RESET;
            exact_length_reg    <= 1'b0;
            single_channel_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_DISCARD_COUNT:   discard_count_reg   <= cfg.data[3:0];
                REG_MIN_LINE_LENGTH: min_line_length_reg <= cfg.data;
                REG_EXACT_LENGTH:    exact_length_reg    <= cfg.data[0];
                REG_SINGLE_CHANNEL:  single_channel_reg  <= cfg.data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_select_reg        <= 1'b0;
            discard_left_reg      <= '0;
            last_value_reg        <= '0;
            stable_mark_reg       <= 1'b0;
            stable_weights_reg[0] <= '0;
            stable_weights_reg[1] <= '0;
        end
        else if (rx_fire && info.closes)
        begin
            if (emit)
            begin
                last_value_reg  <= value_next;
                stable_mark_reg <= mark_next;
                if (mark_next)
                    stable_weights_reg[sw_idx] <= value_next;
            end
            else if (old_select_reg != rx.channel_select)
            begin
                old_select_reg   <= rx.channel_select;
                discard_left_reg <= discard_count_reg;
            end
            else
            begin
                discard_left_reg <= discard_left_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (res_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_ch_one_reg        <= ch_one;
            out_weight_reg        <= value_next;
            out_stable_reg        <= mark_next;
            out_stable_weight_reg <= stable_weight_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.to_channel_one = out_ch_one_reg;
    assign res.weight         = out_weight_reg;
    assign res.is_stable      = out_stable_reg;
    assign res.stable_weight  = out_stable_weight_reg;

    // A stable line stores its own weight, so both values must agree.
    a_stable_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stable_reg) |-> (out_stable_weight_reg == out_weight_reg))
        else $error("stable weight differs from weight on a stable line");

    // A new result only ever follows a byte that closed a line.
    a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rx_fire && info.closes))
        else $error("result appeared without a closing line feed");

    // The discard counter moves only on a closed line.
    a_discard_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (discard_left_reg != $past(discard_left_reg)) |-> $past(rx_fire && info.closes))
        else $error("discard counter changed without a closed line");

    // A held result that is not taken must block further bytes.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !rx_fire)
        else $error("byte accepted while a result was stalled");

endmodule

// File: tb/weighing_line_parser_tb.sv
// Self-checking testbench for the weighing line parser: scale lines and noise checked per line.
module weighing_line_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlp_pkg::*;

    localparam int RESET_CYCLES  = 12;
    // The long receiver hold-off used to fill the result register and stall the byte input.
    localparam int HOLD_CYCLES   = 400;
    // The block holds one result register, so a few cycles cover anything still in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;
    // Slots of the held stable weights: channel one first, channel two second.
    localparam int SLOT_ONE      = 0;
    localparam int SLOT_TWO      = 1;

    // One parsed line as it appears on the result channel.
    typedef struct packed {
        logic                to_channel_one;
        logic [WEIGHT_W-1:0] weight;
        logic                is_stable;
        logic [WEIGHT_W-1:0] stable_weight;
    } line_result_t;

    // Scoreboard: follows every accepted byte with its own copy of the parse state and
    // keeps the parsed lines that the block still owes, oldest first.
    class line_scoreboard;
        // Register copies.
        logic [3:0]          skip_setting;
        logic [COUNT_W-1:0]  min_len;
        logic                exact_mode;
        logic                single_mode;

        // State of the line being collected.
        logic [COUNT_W-1:0]  line_len;
        logic [2:0]          tokens_done;
        logic                token_open;
        logic [1:0]          head_pos;
        logic                head_has_t;
        logic                text_stopped;
        logic                has_weight_token;
        logic [3:0]          digits_seen;
        logic [WEIGHT_W-1:0] weight_acc;

        // State that outlives a line.
        logic [WEIGHT_W-1:0] prev_weight;
        logic                prev_select;
        logic [3:0]          lines_to_skip;
        logic [WEIGHT_W-1:0] held_stable [2];
        logic                stable_flag;

        line_result_t        pending[$];
        int                  mismatches;

        function new();
            skip_setting   = DISCARD_RESET;
            min_len        = MIN_RESET;
            exact_mode     = 1'b0;
            single_mode    = 1'b0;
            prev_weight    = '0;
            prev_select    = 1'b0;
            lines_to_skip  = '0;
            held_stable[SLOT_ONE] = '0;
            held_stable[SLOT_TWO] = '0;
            stable_flag    = 1'b0;
            mismatches     = 0;
            restart_line();
        endfunction

        function void restart_line();
            line_len         = '0;
            tokens_done      = '0;
            token_open       = 1'b0;
            head_pos         = '0;
            head_has_t       = 1'b0;
            text_stopped     = 1'b0;
            has_weight_token = 1'b0;
            digits_seen      = '0;
            weight_acc       = '0;
        endfunction

        function void apply_register(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_DISCARD_COUNT:   skip_setting = value[3:0];
                REG_MIN_LINE_LENGTH: min_len      = value;
                REG_EXACT_LENGTH:    exact_mode   = value[0];
                REG_SINGLE_CHANNEL:  single_mode  = value[0];
                default:             ;
            endcase
        endfunction

        // Tokeniser: commas split the text, a zero byte ends it, and only the first
        // and the fourth token carry meaning.
        function void take_char(logic [BYTE_W-1:0] b);
            if (text_stopped)
                return;
            if (b == CHAR_NUL)
            begin
                text_stopped = 1'b1;
                return;
            end
            if (b == CHAR_COMMA)
            begin
                if (token_open)
                begin
                    token_open = 1'b0;
                    if (tokens_done < TOKEN_MAX)
                        tokens_done++;
                end
                return;
            end
            if (!token_open)
            begin
                token_open = 1'b1;
                if (tokens_done == 0)
                begin
                    head_pos   = '0;
                    head_has_t = 1'b0;
                end
                else if (tokens_done == TOKEN_WGT)
                begin
                    has_weight_token = 1'b1;
                    weight_acc       = '0;
                    digits_seen      = '0;
                end
            end
            if (tokens_done == 0)
            begin
                if (head_pos == 1 && b == CHAR_T)
                    head_has_t = 1'b1;
                if (head_pos < FIRST_MAX)
                    head_pos++;
            end
            else if (tokens_done == TOKEN_WGT)
            begin
                if (b >= CHAR_ZERO && b <= CHAR_NINE && digits_seen < MAX_DIGITS)
                begin
                    weight_acc  = WEIGHT_W'(weight_acc * 10 + (b - CHAR_ZERO));
                    digits_seen++;
                end
            end
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic sel);
            logic         closes;
            logic         ch_one;
            int           slot;
            line_result_t due;
            if (b == CHAR_LF)
                closes = exact_mode ? (line_len == min_len) : (line_len >= min_len);
            else
                closes = 1'b0;
            if (!closes)
            begin
                // A byte that finds the line full throws the whole line away.
                if (line_len >= MAX_LINE)
                begin
                    restart_line();
                end
                else
                begin
                    take_char(b);
                    line_len++;
                end
                return;
            end
            take_char(b);
            if (single_mode)
            begin
                ch_one = 1'b1;
            end
            else if (prev_select != sel)
            begin
                prev_select   = sel;
                lines_to_skip = skip_setting;
                restart_line();
                return;
            end
            else if (lines_to_skip != 0)
            begin
                lines_to_skip--;
                restart_line();
                return;
            end
            else
            begin
                ch_one = sel;
            end
            if (tokens_done != 0 || token_open)
                stable_flag = head_has_t;
            if (has_weight_token)
                prev_weight = weight_acc;
            slot = ch_one ? SLOT_ONE : SLOT_TWO;
            if (stable_flag)
                held_stable[slot] = prev_weight;
            due.to_channel_one = ch_one;
            due.weight         = prev_weight;
            due.is_stable      = stable_flag;
            due.stable_weight  = held_stable[slot];
            pending.push_back(due);
            restart_line();
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void check_line(line_result_t got);
            line_result_t due;
            if (pending.size() == 0)
            begin
                note_failure($sformatf("unexpected line ch1=%0d weight=%0d stable=%0d held=%0d",
                    got.to_channel_one, got.weight, got.is_stable, got.stable_weight));
                return;
            end
            due = pending.pop_front();
            if (got.to_channel_one !== due.to_channel_one || got.weight !== due.weight ||
                got.is_stable !== due.is_stable || got.stable_weight !== due.stable_weight)
                note_failure($sformatf({"expected ch1=%0d weight=%0d stable=%0d held=%0d, ",
                                        "got ch1=%0d weight=%0d stable=%0d held=%0d"},
                    due.to_channel_one, due.weight, due.is_stable, due.stable_weight,
                    got.to_channel_one, got.weight, got.is_stable, got.stable_weight));
        endfunction

        function void flush_leftover();
            if (pending.size() != 0)
                note_failure($sformatf("%0d expected lines never arrived", pending.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wlp_rx_if  rx_bus ();
    wlp_res_if res_bus ();
    wlp_cfg_if cfg_bus ();

    weighing_line_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    line_scoreboard      board = new();
    int unsigned         bytes_sent = 0;
    // Set by the stimulus to ask the receiver for one long hold-off; cleared by the receiver.
    logic                hold_request = 1'b0;
    // Set for the closing stretch of the run: no idling on either side from then on.
    logic                calm = 1'b0;
    // Channel select that the generated lines are closed with.
    logic                line_select = 1'b1;
    logic [BYTE_W-1:0]   line_text[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Every transaction is sampled at the rising edge, before the block's own updates land.
    // A result accepted on an edge belongs to earlier bytes, so it is checked before the
    // byte of the same edge is fed to the scoreboard.
    always @(posedge clk)
    begin
        line_result_t seen;
        if (rst_n === 1'b1)
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                seen.to_channel_one = res_bus.to_channel_one;
                seen.weight         = res_bus.weight;
                seen.is_stable      = res_bus.is_stable;
                seen.stable_weight  = res_bus.stable_weight;
                board.check_line(seen);
            end
            if (cfg_bus.valid && cfg_bus.ready)
                board.apply_register(cfg_bus.index, cfg_bus.data);
            if (rx_bus.valid && rx_bus.ready)
                board.note_byte(rx_bus.rx_byte, rx_bus.channel_select);
        end
    end

    // Receiver: ready comes and goes in bursts, with occasional long open stretches, one
    // long hold-off on request, and no stalls at all once the run turns calm. A request
    // for the hold-off cuts the current burst short so that it starts at once.
    initial
    begin : receiver
        int span;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                res_bus.ready <= 1'b0;
                for (span = 0; span < HOLD_CYCLES; span++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else if (calm || $urandom_range(0, 3) != 0)
            begin
                res_bus.ready <= 1'b1;
                if (calm)
                    span = 1;
                else if ($urandom_range(0, 4) == 0)
                    span = $urandom_range(40, 120);
                else
                    span = $urandom_range(1, 15);
                repeat (span)
                begin
                    if (hold_request)
                        break;
                    @(posedge clk);
                end
            end
            else
            begin
                res_bus.ready <= 1'b0;
                span = $urandom_range(1, 15);
                repeat (span)
                begin
                    if (hold_request)
                        break;
                    @(posedge clk);
                end
            end
        end
    end

    // Offers one byte and waits for its transaction; now and then leaves a gap after it.
    task automatic send_byte(logic [BYTE_W-1:0] value, logic sel);
        rx_bus.valid          <= 1'b1;
        rx_bus.rx_byte        <= value;
        rx_bus.channel_select <= sel;
        do
            @(posedge clk);
        while (!rx_bus.ready);
        bytes_sent++;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send_string(string text, logic sel);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], sel);
    endtask

    // Stops offering bytes and waits until every owed line has come out, plus a margin.
    task automatic wait_drained();
        rx_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
    endtask

    // Registers are only touched once the parser has gone quiet.
    task automatic configure(int skip, int min_bytes, int exact, int single);
        wait_drained();
        write_register(REG_DISCARD_COUNT, CFG_W'(skip));
        write_register(REG_MIN_LINE_LENGTH, CFG_W'(min_bytes));
        write_register(REG_EXACT_LENGTH, CFG_W'(exact));
        write_register(REG_SINGLE_CHANNEL, CFG_W'(single));
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic void add_text(string text);
        for (int i = 0; i < text.len(); i++)
            line_text.push_back(text[i]);
    endfunction

    function automatic logic [BYTE_W-1:0] random_letter();
        return BYTE_W'($urandom_range(8'h41, 8'h5A));
    endfunction

    // Any byte but a line feed, so that padding never closes the line early.
    function automatic logic [BYTE_W-1:0] filler_char();
        logic [BYTE_W-1:0] c;
        c = BYTE_W'($urandom_range(1, 255));
        if (c == CHAR_LF)
            c = CHAR_COMMA;
        return c;
    endfunction

    // Body length that mostly lets the closing line feed end the line under the current
    // registers; one line in ten gets any length, overlong ones included.
    function automatic int unsigned pick_body_length();
        int unsigned lo;
        lo = board.min_len;
        if ($urandom_range(0, 9) == 0 || lo > MAX_LINE)
            return $urandom_range(0, MAX_LINE + 2);
        if (board.exact_mode)
            return lo;
        return $urandom_range(lo, MAX_LINE);
    endfunction

    // Builds an indicator-style line such as "ST,GS,+,001234kg" and fits it to the length.
    function automatic void compose_line(int unsigned body_len);
        int unsigned digits;
        line_text.delete();
        case ($urandom_range(0, 4))
            0: add_text("ST");
            1: add_text("US");
            2: add_text("T");
            3: add_text("GT");
            default:
            begin
                line_text.push_back(random_letter());
                line_text.push_back($urandom_range(0, 1) ? CHAR_T : random_letter());
                if ($urandom_range(0, 1))
                    line_text.push_back(random_letter());
            end
        endcase
        // Doubled commas make empty tokens, which must not count.
        if ($urandom_range(0, 3) == 0)
            add_text(",,");
        add_text(",GS,");
        if ($urandom_range(0, 1))
            add_text("+");
        else
            add_text("-");
        add_text(",");
        digits = $urandom_range(0, 12);
        repeat (digits)
            line_text.push_back(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 1))
            add_text("kg");
        if ($urandom_range(0, 7) == 0)
            line_text.push_back(CHAR_NUL);
        if ($urandom_range(0, 3) == 0)
            add_text(",9");
        while (line_text.size() > body_len)
            void'(line_text.pop_back());
        while (line_text.size() < body_len)
            line_text.push_back($urandom_range(0, 3) == 0 ? filler_char() : 8'h20);
    endfunction

    task automatic send_line();
        compose_line(pick_body_length());
        foreach (line_text[i])
            send_byte(line_text[i], 1'($urandom));
        send_byte(CHAR_LF, line_select);
    endtask

    // Raw bytes of any value, stray line feeds favoured, with random channel select.
    task automatic send_noise();
        repeat ($urandom_range(1, 30))
            send_byte($urandom_range(0, 7) == 0 ? CHAR_LF : BYTE_W'($urandom), 1'($urandom));
    endtask

    // Mostly well-formed lines with random content, some noise, and the odd channel switch.
    task automatic run_traffic(int unsigned amount);
        int unsigned stop_at;
        stop_at = bytes_sent + amount;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_noise();
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    line_select = ~line_select;
                send_line();
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n                 <= 1'b0;
        rx_bus.valid          <= 1'b0;
        rx_bus.rx_byte        <= '0;
        rx_bus.channel_select <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_DISCARD_COUNT;
        cfg_bus.data          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines with a zero minimum, so that any line feed closes a line.
        configure(0, 0, 0, 0);
        // The first select of one differs from the reset select: the line is swallowed.
        send_byte(CHAR_LF, 1'b1);
        // An empty line: no token, so the previous weight and stable flag are repeated.
        send_byte(CHAR_LF, 1'b1);
        // Stable first token and a fourth token of eleven nines: ten digits count, wrapped.
        send_string("ST,a,b,99999999999", 1'b1);
        send_byte(CHAR_LF, 1'b1);
        // A one-character first token is never stable; no fourth token keeps the old weight.
        send_string("T,,c", 1'b1);
        send_byte(CHAR_LF, 1'b1);
        // A fourth token without digits gives zero; the zero byte hides the rest.
        send_string("AT,1,2,kg", 1'b1);
        send_byte(CHAR_NUL, 1'b1);
        send_string(",9", 1'b1);
        send_byte(CHAR_LF, 1'b1);
        // Switch to channel two, then one line on it.
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CHAR_LF, 1'b0);

        // Reset values written back explicitly.
        configure(1, 21, 0, 0);
        run_traffic(200);
        // A minimum of one byte, no discards.
        configure(0, 1, 0, 0);
        run_traffic(150);
        // Longest exact line and the deepest discard count.
        configure(15, MAX_LINE, 1, 0);
        run_traffic(200);
        // Single channel mode: selects are ignored and nothing is discarded.
        configure(3, 10, 1, 1);
        run_traffic(150);
        configure(2, 5, 0, 0);
        run_traffic(150);
        // Zero minimum in single channel mode.
        configure(0, 0, 0, 1);
        run_traffic(80);
        // Minimum beyond the line buffer: lines only overflow and never close.
        configure(4, 27, 0, 0);
        run_traffic(60);

        // Last phase: the receiver holds off for a long stretch while bytes keep coming,
        // the sender pauses until the block is empty, and the run ends without idling.
        configure(0, 12, 0, 0);
        hold_request = 1'b1;
        run_traffic(100);
        wait_drained();
        run_traffic(100);
        calm = 1'b1;
        run_traffic(150);

        wait_drained();
        board.flush_leftover();
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Far beyond the slowest correct run, stalls and the long hold-off included.
    initial
    begin : watchdog
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/wlp_pkg.sv
hw/rtl/wlp_interfaces.sv
hw/rtl/wlp_tokenizer.sv
hw/rtl/weighing_line_parser.sv
tb/weighing_line_parser_tb.sv
